// ===== design/mdcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdcf_pkg
// Field widths and verdict codes shared by the duplicate command filter.
// ----------------------------------------------------------------------------
package mdcf_pkg;

    localparam int LEN_W     = 16;
    localparam int MAC_W     = 48;
    localparam int SEQ_W     = 16;
    localparam int VERDICT_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [MAC_W-1:0]     t_mac;
    typedef logic [SEQ_W-1:0]     t_seq;
    typedef logic [VERDICT_W-1:0] t_verdict;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_W-1:0]     t_cfg;

    // verdict codes
    localparam t_verdict V_OK      = 3'd0;
    localparam t_verdict V_SHORT   = 3'd1;
    localparam t_verdict V_BADMAC  = 3'd2;
    localparam t_verdict V_DUP     = 3'd3;
    localparam t_verdict V_FOREIGN = 3'd4;

    // configuration register indexes
    localparam t_cfg_idx CFG_MIN_LEN_CMD    = 1'd0;
    localparam t_cfg_idx CFG_MIN_LEN_NOTIFY = 1'd1;

    // stored sequence assumed for a neighbour not in the list
    localparam t_seq SEQ_MISS = 16'hFFFF;

endpackage
`default_nettype wire

// ===== design/mru_duplicate_command_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mru_duplicate_command_filter
// Tells new received command frames from repeats, keeping a most-recently-
// used list of neighbour MACs and sequences plus the own sequence register.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  in       | to block  | i_in_valid / o_in_stall | notify, len, mac, seq, own_net
//  out      | from block| o_out_valid / i_out_stall| accept, verdict
//  cfg      | to block  | i_cfg_we                | i_cfg_idx, i_cfg_data
//
//  A transaction is taken only in idle. A command frame, and a notify
//  rejected for length or MAC, goes from the check step to done; any other
//  notify is scanned, one neighbour entry a cycle from the list memory, until
//  its MAC is found or the last position is compared, then updates the list.
//  Reset (synchronous, active low) restores list order and entry valid bits at
//  once; the list memory itself needs no clearing. A stalled result sits in
//  the output register while the next transaction is taken and worked on.
// ----------------------------------------------------------------------------
module mru_duplicate_command_filter #(
    parameter int NEIGHBOURS = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // configuration
    input  wire                       i_cfg_we,
    input  wire mdcf_pkg::t_cfg_idx   i_cfg_idx,
    input  wire mdcf_pkg::t_cfg       i_cfg_data,
    // frame input
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire                       i_neighbour_notify,
    input  wire mdcf_pkg::t_len       i_frame_len,
    input  wire mdcf_pkg::t_mac       i_src_mac,
    input  wire mdcf_pkg::t_seq       i_frame_seq,
    input  wire                       i_own_net,
    // verdict output
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic                      o_accept,
    output mdcf_pkg::t_verdict        o_verdict
);
    import mdcf_pkg::*;

    localparam int IDXW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam logic [IDXW-1:0] LAST_POS = IDXW'(NEIGHBOURS - 1);
    localparam int ENT_W = MAC_W + SEQ_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;

    // configuration registers
    t_len              r_min_len_cmd;
    t_len              r_min_len_notify;

    // captured frame
    logic              r_notify;
    t_len              r_len;
    t_mac              r_mac;
    t_seq              r_seq;
    logic              r_own;

    // own network sequence
    t_seq              r_own_seq;
    logic              r_own_seq_valid;

    // list: physical slot at each MRU position, and slot valid bits
    logic [IDXW-1:0]   r_order [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] r_valid;

    // neighbour memory {mac, seq}
    logic [ENT_W-1:0]  mem [NEIGHBOURS];
    logic [ENT_W-1:0]  r_rd_data;
    logic [IDXW-1:0]   rd_addr;
    logic              mem_we;
    logic [IDXW-1:0]   wr_slot;

    // scan pipeline
    logic [IDXW-1:0]   r_pos;
    logic              r_cmp_vld;
    logic [IDXW-1:0]   r_cmp_pos;
    logic [IDXW-1:0]   r_cmp_slot;
    logic [IDXW-1:0]   r_hit_pos;
    t_seq              r_old_seq;

    // result
    logic              r_res_accept;
    t_verdict          r_res_verdict;
    logic              r_out_valid;
    logic              r_out_accept;
    t_verdict          r_out_verdict;

    logic              in_take;
    logic              out_free;
    logic              too_short;
    logic              bad_mac;
    logic              cmp_hit;
    logic              cmp_last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_accept    = r_out_accept;
    assign o_verdict   = r_out_verdict;

    // frame checks on the captured transaction
    assign too_short = r_notify ? (r_len < r_min_len_notify) : (r_len < r_min_len_cmd);
    assign bad_mac   = (r_mac == '0) || (r_mac == '1);

    // compare stage of the scan
    assign cmp_hit  = r_cmp_vld && r_valid[r_cmp_slot] &&
                      (r_rd_data[ENT_W-1:SEQ_W] == r_mac);
    assign cmp_last = r_cmp_vld && (r_cmp_pos == LAST_POS);

    assign rd_addr = r_order[r_pos];
    assign mem_we  = (r_state == ST_UPDATE);
    assign wr_slot = r_order[r_hit_pos];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len_cmd    <= '0;
            r_min_len_notify <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_LEN_CMD:    r_min_len_cmd    <= i_cfg_data;
                CFG_MIN_LEN_NOTIFY: r_min_len_notify <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_notify && !too_short && !bad_mac) n_state = ST_SCAN;
                else                                    n_state = ST_DONE;
            end
            ST_SCAN:   if (cmp_hit || cmp_last) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_notify <= i_neighbour_notify;
            r_len    <= i_frame_len;
            r_mac    <= i_src_mac;
            r_seq    <= i_frame_seq;
            r_own    <= i_own_net;
        end
    end

    // neighbour memory, one read and one write port, read registered.
    // Writes occur only in the update step, after the scan of the same
    // transaction is over, so reads never meet a pending write.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wr_slot] <= {r_mac, r_seq};
        r_rd_data <= mem[rd_addr];
    end

    // scan: issue one position a cycle, compare the previous one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_cmp_vld <= 1'b1;
        end else begin
            r_cmp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_pos <= '0;
        end else if (r_state == ST_SCAN) begin
            r_cmp_pos  <= r_pos;
            r_cmp_slot <= r_order[r_pos];
            if (r_pos != LAST_POS) r_pos <= r_pos + 1'b1;
            if (cmp_hit || cmp_last) begin
                r_hit_pos <= r_cmp_pos;
                r_old_seq <= cmp_hit ? r_rd_data[SEQ_W-1:0] : SEQ_MISS;
            end
        end
    end

    // list order and valid bits: move hit (or oldest) entry to front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NEIGHBOURS; i++) r_order[i] <= IDXW'(i);
            r_valid <= '0;
        end else if (r_state == ST_UPDATE) begin
            r_order[0] <= r_order[r_hit_pos];
            for (int i = 1; i < NEIGHBOURS; i++) begin
                if (IDXW'(i) <= r_hit_pos) r_order[i] <= r_order[i-1];
            end
            r_valid[wr_slot] <= 1'b1;
        end
    end

    // verdict and own sequence register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_seq       <= '0;
            r_own_seq_valid <= 1'b0;
        end else if (r_state == ST_CHECK) begin
            priority if (too_short) begin
                r_res_verdict <= V_SHORT;
                r_res_accept  <= 1'b0;
            end else if (r_notify && bad_mac) begin
                r_res_verdict <= V_BADMAC;
                r_res_accept  <= 1'b0;
            end else if (r_notify) begin
                r_res_verdict <= V_OK;
                r_res_accept  <= 1'b0;
            end else if (!r_own) begin
                r_res_verdict <= V_FOREIGN;
                r_res_accept  <= 1'b0;
            end else if (r_own_seq_valid && (r_own_seq == r_seq)) begin
                r_res_verdict <= V_DUP;
                r_res_accept  <= 1'b0;
            end else begin
                r_res_verdict   <= V_OK;
                r_res_accept    <= 1'b1;
                r_own_seq       <= r_seq;
                r_own_seq_valid <= 1'b1;
            end
        end else if (r_state == ST_UPDATE) begin
            if (r_seq == r_old_seq) begin
                r_res_verdict <= V_DUP;
                r_res_accept  <= 1'b0;
            end else begin
                r_res_verdict <= V_OK;
                r_res_accept  <= 1'b1;
                if (r_own) begin
                    r_own_seq       <= r_seq;
                    r_own_seq_valid <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_accept  <= r_res_accept;
            r_out_verdict <= r_res_verdict;
        end
    end

`ifndef NO_ASSERTIONS
    // set of slots named by the order list
    logic [NEIGHBOURS-1:0] chk_slots;
    always_comb begin
        chk_slots = '0;
        for (int i = 0; i < NEIGHBOURS; i++) chk_slots[r_order[i]] = 1'b1;
    end

    a_order_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(chk_slots) == NEIGHBOURS)
        else $error("order list is not a permutation of the slots");

    a_accept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accept == (o_verdict == V_OK)))
        else $error("accept flag disagrees with verdict");

    a_valid_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_valid != $past(r_valid))) |-> ($past(r_state) == ST_UPDATE))
        else $error("slot valid bits changed outside the update step");

    a_take_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == ST_CHECK))
        else $error("accepted transaction did not start a check");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && i_out_stall) |=> (r_state == ST_DONE))
        else $error("result left while the output register was full");
`endif

endmodule
`default_nettype wire

// ===== verif/mru_duplicate_command_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_duplicate_command_filter_tb
// Self-checking bench for the duplicate command filter. A queue-fed driver
// offers frames in bursts and a monitor checks each verdict against an
// in-bench model of the neighbour MRU list and the own sequence register.
// Length floors change between phases, the receiver stalls on varying
// patterns, and it holds off once for a long stretch.
// ----------------------------------------------------------------------------
module mru_duplicate_command_filter_tb;

    import mdcf_pkg::*;

    localparam int NB          = 8;
    localparam int POOL        = 11;      // MACs reused by random frames
    localparam int SETTLE      = 40;      // cycles after the last verdict
    localparam int HOLD_AT     = 300;     // frames taken before the hold-off
    localparam int HOLD_CYCLES = 500;
    localparam int LIMIT       = 400000;

    typedef struct packed {
        logic notify;
        t_len len;
        t_mac mac;
        t_seq seq;
        logic own;
    } t_frame;

    typedef struct packed {
        logic     accept;
        t_verdict verdict;
    } t_ruling;

    typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // DUT connections, known from time zero
    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_cfg_we    = 1'b0;
    t_cfg_idx i_cfg_idx   = CFG_MIN_LEN_CMD;
    t_cfg     i_cfg_data  = '0;
    logic     i_in_valid  = 1'b0;
    logic     i_neighbour_notify = 1'b0;
    t_len     i_frame_len = '0;
    t_mac     i_src_mac   = '0;
    t_seq     i_frame_seq = '0;
    logic     i_own_net   = 1'b0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    logic     o_accept;
    t_verdict o_verdict;

    mru_duplicate_command_filter #(
        .NEIGHBOURS (NB)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_neighbour_notify (i_neighbour_notify),
        .i_frame_len        (i_frame_len),
        .i_src_mac          (i_src_mac),
        .i_frame_seq        (i_frame_seq),
        .i_own_net          (i_own_net),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accept           (o_accept),
        .o_verdict          (o_verdict)
    );

    // bench state
    t_frame   frames_to_send[$];
    t_ruling  rulings_due[$];
    int       errors       = 0;
    int       frames_taken = 0;
    int       checked      = 0;
    int       settings     = 0;
    int       verdict_seen[5];
    int       burst_left   = 1;
    int       gap_left     = 0;
    int       hold_cnt     = 0;
    logic     hold_done    = 1'b0;
    int       rx_tick      = 0;
    int       cycles       = 0;
    t_rx_mode rx_mode      = RX_STEADY;
    t_frame   taken;
    t_frame   next_frame;
    t_ruling  want;
    logic     rx_stall;

    // model state: length floors, MRU list, own sequence
    t_cfg     cmd_floor    = '0;
    t_cfg     notify_floor = '0;
    t_mac     mru_mac[NB];
    t_seq     mru_seq[NB];
    t_seq     own_seq      = '0;
    logic     own_seq_ok   = 1'b0;

    // generator memory for building repeats
    t_mac     mac_pool[POOL];
    t_seq     pool_seq[POOL];
    t_seq     last_cmd_seq = '0;

    initial begin
        for (int i = 0; i < NB; i++) begin
            mru_mac[i] = '0;
            mru_seq[i] = '0;
        end
        for (int i = 0; i < 5; i++) verdict_seen[i] = 0;
    end

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // verdict for one frame, updating the list and own sequence
    function automatic t_verdict judge_frame(input t_frame f);
        int   hit;
        int   top;
        t_seq old;
        hit = NB;
        old = SEQ_MISS;
        if (f.notify) begin
            if (f.len < notify_floor) return V_SHORT;
            if (f.mac == '0 || f.mac == '1) return V_BADMAC;
            for (int i = 0; i < NB; i++) begin
                if (hit == NB && mru_mac[i] == f.mac) begin
                    hit = i;
                    old = mru_seq[i];
                end
            end
            // hit entry or oldest entry drops out, the rest shift back
            top = (hit < NB - 1) ? hit : NB - 1;
            for (int i = top; i > 0; i--) begin
                mru_mac[i] = mru_mac[i-1];
                mru_seq[i] = mru_seq[i-1];
            end
            mru_mac[0] = f.mac;
            mru_seq[0] = f.seq;
            if (f.seq == old) return V_DUP;
            if (f.own) begin
                own_seq    = f.seq;
                own_seq_ok = 1'b1;
            end
            return V_OK;
        end
        if (f.len < cmd_floor) return V_SHORT;
        if (!f.own) return V_FOREIGN;
        if (own_seq_ok && own_seq == f.seq) return V_DUP;
        own_seq    = f.seq;
        own_seq_ok = 1'b1;
        return V_OK;
    endfunction

    function automatic t_frame mk(input logic notify, input t_len len, input t_mac mac,
                                  input t_seq seq, input logic own);
        t_frame f;
        f.notify = notify;
        f.len    = len;
        f.mac    = mac;
        f.seq    = seq;
        f.own    = own;
        return f;
    endfunction

    // driver: predicts on acceptance, then offers the next frame
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                taken  = mk(i_neighbour_notify, i_frame_len, i_src_mac, i_frame_seq,
                            i_own_net);
                want.verdict = judge_frame(taken);
                want.accept  = (want.verdict == V_OK);
                rulings_due.push_back(want);
                frames_taken++;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_LEN_CMD) cmd_floor = i_cfg_data;
                else if (i_cfg_idx == CFG_MIN_LEN_NOTIFY) notify_floor = i_cfg_data;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (frames_to_send.size() != 0) begin
                    next_frame = frames_to_send.pop_front();
                    i_neighbour_notify <= next_frame.notify;
                    i_frame_len        <= next_frame.len;
                    i_src_mac          <= next_frame.mac;
                    i_frame_seq        <= next_frame.seq;
                    i_own_net          <= next_frame.own;
                    i_in_valid         <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(24, 1);
                        gap_left   <= ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(8, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each verdict transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rulings_due.size() == 0) begin
                if (errors < 10)
                    $display("unexpected verdict transaction: accept %0b verdict %0d",
                             o_accept, o_verdict);
                errors++;
            end else begin
                want = rulings_due.pop_front();
                if (o_accept !== want.accept || o_verdict !== want.verdict) begin
                    if (errors < 10)
                        $display("result %0d: expected accept %0b verdict %0d, got %0b %0d",
                                 checked, want.accept, want.verdict, o_accept, o_verdict);
                    errors++;
                end
                if (o_verdict <= V_FOREIGN) verdict_seen[o_verdict]++;
                checked++;
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && frames_taken >= HOLD_AT) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_STEADY:   rx_stall = 1'b0;
            RX_LIGHT:    rx_stall = ($urandom_range(99, 0) < 25);
            RX_HEAVY:    rx_stall = ($urandom_range(99, 0) < 70);
            default:     rx_stall = ((rx_tick % 7) < 3);
        endcase
        i_out_stall <= rx_stall || (hold_cnt != 0);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("mru_duplicate_command_filter: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input t_cfg val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_limits(input t_cfg cmd_min, input t_cfg notify_min, input t_rx_mode mode);
        write_reg(CFG_MIN_LEN_CMD, cmd_min);
        write_reg(CFG_MIN_LEN_NOTIFY, notify_min);
        rx_mode = mode;
        settings++;
    endtask

    // wait for every frame to go in and every verdict to come back;
    // sampled mid-cycle so the driver's updates at the edge have settled
    task automatic drain();
        while (frames_to_send.size() != 0 || rulings_due.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_cfg cmd_min, input t_cfg notify_min, input int count,
                             input t_rx_mode mode);
        t_frame f;
        int     r;
        int     k;
        int     floor;
        set_limits(cmd_min, notify_min, mode);
        for (int n = 0; n < count; n++) begin
            f.notify = ($urandom_range(99, 0) < 60);
            f.own    = ($urandom_range(99, 0) < 75);
            floor    = int'(f.notify ? notify_min : cmd_min);
            // mostly long enough, some just short, some anything
            r = $urandom_range(99, 0);
            if (r < 70)                    f.len = t_len'($urandom_range(65535, floor));
            else if (r < 85 && floor != 0) f.len = t_len'($urandom_range(floor - 1, 0));
            else                           f.len = t_len'($urandom);
            r = $urandom_range(99, 0);
            k = -1;
            if (r < 3)       f.mac = '0;
            else if (r < 6)  f.mac = '1;
            else if (r < 16) f.mac = t_mac'({$urandom, $urandom});
            else begin
                k     = $urandom_range(POOL - 1, 0);
                f.mac = mac_pool[k];
            end
            r = $urandom_range(99, 0);
            if (f.notify) begin
                if (k >= 0 && r < 35) f.seq = pool_seq[k];
                else if (r < 45)      f.seq = SEQ_MISS;
                else                  f.seq = t_seq'($urandom);
                if (k >= 0) pool_seq[k] = f.seq;
            end else begin
                f.seq = (r < 35) ? last_cmd_seq : t_seq'($urandom);
                last_cmd_seq = f.seq;
            end
            frames_to_send.push_back(f);
        end
        drain();
    endtask

    // stimulus
    initial begin
        for (int i = 0; i < POOL; i++) begin
            mac_pool[i] = t_mac'({$urandom, $urandom});
            if (mac_pool[i] == '0 || mac_pool[i] == '1) mac_pool[i] = t_mac'(i + 1);
            pool_seq[i] = t_seq'($urandom);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: both frame kinds, every verdict, list edge cases
        set_limits(16'd10, 16'd20, RX_LIGHT);
        frames_to_send.push_back(mk(1'b0, 16'hFFFF, 48'h0, 16'h0000, 1'b1));  // first own seq
        frames_to_send.push_back(mk(1'b0, 16'd50, 48'h0, 16'h0000, 1'b1));    // repeat
        frames_to_send.push_back(mk(1'b0, 16'd100, 48'h0, 16'h1234, 1'b0));   // foreign
        frames_to_send.push_back(mk(1'b0, 16'd0, 48'h0, 16'h4321, 1'b1));     // short command
        frames_to_send.push_back(mk(1'b0, 16'd10, 48'h0, 16'hFFFF, 1'b1));    // at the floor
        frames_to_send.push_back(mk(1'b1, 16'd19, 48'h0, 16'h0001, 1'b1));    // short notify
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'h0, 16'h0001, 1'b1));    // zero MAC
        frames_to_send.push_back(mk(1'b1, 16'd20, '1, 16'h0001, 1'b1));       // all-ones MAC
        frames_to_send.push_back(mk(1'b1, 16'd30, 48'h0000_1234_5678, 16'hFFFF, 1'b1)); // miss
        frames_to_send.push_back(mk(1'b1, 16'd30, 48'h0000_1234_5678, 16'hFFFF, 1'b1)); // hit
        frames_to_send.push_back(mk(1'b1, 16'd30, 48'h0000_1234_5678, 16'h0005, 1'b1));
        frames_to_send.push_back(mk(1'b0, 16'd30, 48'h0, 16'h0005, 1'b1));    // own seq from notify
        frames_to_send.push_back(mk(1'b1, 16'd30, 48'hBEEF_0000_0001, 16'h0007, 1'b0));
        frames_to_send.push_back(mk(1'b0, 16'd30, 48'h0, 16'h0007, 1'b1));    // foreign notify kept own
        // fill the list until the first MAC drops out
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'h0000_0000_0001, 16'h0001, 1'b1));
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'hFFFF_FFFF_FFFE, 16'h0002, 1'b0));
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'h8000_0000_0000, 16'h0003, 1'b1));
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'h7FFF_FFFF_FFFF, 16'h0004, 1'b0));
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'hA5A5_A5A5_A5A5, 16'h0005, 1'b1));
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'h5A5A_5A5A_5A5A, 16'h0006, 1'b1));
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'h0000_0000_0002, 16'h0007, 1'b1));
        frames_to_send.push_back(mk(1'b1, 16'd20, 48'h0000_1234_5678, 16'h0005, 1'b1)); // evicted
        frames_to_send.push_back(mk(1'b1, 16'hFFFF, 48'h0000_0000_0001, 16'h0001, 1'b1)); // last slot
        drain();

        // random phases over floor settings and receiver patterns
        run_phase(16'd0, 16'd0, 130, RX_STEADY);
        run_phase(16'hFFFF, 16'hFFFF, 100, RX_LIGHT);
        run_phase(16'd0, 16'hFFFF, 130, RX_HEAVY);
        run_phase(16'hFFFF, 16'd0, 130, RX_PERIODIC);
        run_phase(t_cfg'($urandom), t_cfg'($urandom), 150, RX_LIGHT);
        run_phase(t_cfg'($urandom_range(600, 0)), t_cfg'($urandom_range(600, 0)), 150,
                  RX_HEAVY);

        if (rulings_due.size() != 0) errors += rulings_due.size();
        $display("checked %0d verdicts over %0d floor settings, with a %0d-cycle output hold-off",
                 checked, settings, HOLD_CYCLES);
        $display("verdicts seen: accepted %0d, short %0d, bad MAC %0d, duplicate %0d, foreign %0d",
                 verdict_seen[V_OK], verdict_seen[V_SHORT], verdict_seen[V_BADMAC],
                 verdict_seen[V_DUP], verdict_seen[V_FOREIGN]);
        if (errors == 0) begin
            $display("mru_duplicate_command_filter: match");
        end else begin
            $display("mru_duplicate_command_filter: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/mdcf_pkg.sv
design/mru_duplicate_command_filter.sv
verif/mru_duplicate_command_filter_tb.sv
